FILE: rtl/assert_macros.svh
// Assertion macros shared by the checker files.
// No dependencies; clock clk_i and reset rst_ni must be in scope.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Antecedent in this cycle implies consequent in the next cycle.
`define AST_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

// Antecedent implies consequent in the same cycle.
`define AST_SAME(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

`endif

FILE: rtl/snfce_pkg.sv
// Types, codes and constants of the SPI NOR flash command engine.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none
package snfce_pkg;

  localparam int unsigned PAGE_BYTES_DEF = 256;

  typedef enum logic [1:0] {
    REQ_TICK = 2'd0,
    REQ_CMD  = 2'd1,
    REQ_LOAD = 2'd2,
    REQ_NONE = 2'd3
  } req_e;

  typedef enum logic [2:0] {
    OP_READ  = 3'd0,
    OP_PROG  = 3'd1,
    OP_ERASE = 3'd2,
    OP_WREN  = 3'd3,
    OP_PDOWN = 3'd4,
    OP_WAKE  = 3'd5,
    OP_ID    = 3'd6,
    OP_BAD   = 3'd7
  } op_e;

  localparam logic [1:0] CFG_WAKE  = 2'd0;
  localparam logic [1:0] CFG_MAKER = 2'd1;
  localparam logic [1:0] CFG_PART  = 2'd2;

  localparam logic [15:0] WAKE_RST  = 16'd30;
  localparam logic [7:0]  MAKER_RST = 8'hEF;
  localparam logic [7:0]  PART_RST  = 8'h14;
  localparam logic [7:0]  CMD_STATUS = 8'h05;
  localparam logic [7:0]  BUSY_MASK  = 8'h01;

  typedef enum logic [5:0] {
    ST_IDLE  = 6'b000001,
    ST_POLL  = 6'b000010,
    ST_MAIN  = 6'b000100,
    ST_GPOLL = 6'b001000,
    ST_GMAIN = 6'b010000,
    ST_WAIT  = 6'b100000
  } seq_e;

  typedef struct packed {
    logic [1:0]  req_type;
    logic [2:0]  op_code;
    logic [23:0] flash_address;
    logic [8:0]  byte_count;
    logic [7:0]  load_byte;
    logic        miso_bit;
  } in_t;

  typedef struct packed {
    logic       chip_select_n;
    logic       serial_clock;
    logic       serial_out;
    logic [7:0] read_byte;
    logic       read_valid;
    logic       read_last;
    logic       ready_res;
    logic       id_mismatch;
    logic       cmd_rejected;
  } out_t;

  // Classified queue entry.
  typedef struct packed {
    logic is_tick;
    logic is_cmd;
    logic is_load;
    logic op_ok;
    in_t  item;
  } qitem_t;

  function automatic logic [7:0] op_byte(input logic [2:0] op);
    logic [7:0] b;
    case (op)
      OP_READ:  b = 8'h0B;
      OP_PROG:  b = 8'h02;
      OP_ERASE: b = 8'h20;
      OP_WREN:  b = 8'h06;
      OP_PDOWN: b = 8'hB9;
      OP_WAKE:  b = 8'hAB;
      OP_ID:    b = 8'h90;
      default:  b = 8'h00;
    endcase
    return b;
  endfunction

endpackage
`default_nettype wire

FILE: rtl/snfce_front.sv
// Front end: accepts input items, classifies them, holds them in a 2-entry queue.
// Depends on snfce_pkg.
`timescale 1ns / 1ps
`default_nettype none
module snfce_front (
  input  wire logic            clk_i,
  input  wire logic            rst_ni,
  input  wire logic            in_valid_i,
  output logic                 in_stall_o,
  input  wire snfce_pkg::in_t  in_data_i,
  input  wire logic            pop_i,
  output logic                 head_valid_o,
  output snfce_pkg::qitem_t    head_o
);

  snfce_pkg::qitem_t q_mem_q [2];
  logic       wr_ptr_q, rd_ptr_q;
  logic [1:0] cnt_q, cnt_d;
  logic       push, pop;
  snfce_pkg::qitem_t cls;

  always_comb begin
    cls.item    = in_data_i;
    cls.is_tick = (in_data_i.req_type == snfce_pkg::REQ_TICK);
    cls.is_cmd  = (in_data_i.req_type == snfce_pkg::REQ_CMD);
    cls.is_load = (in_data_i.req_type == snfce_pkg::REQ_LOAD);
    cls.op_ok   = (in_data_i.op_code != snfce_pkg::OP_BAD);
  end

  assign in_stall_o   = (cnt_q == 2'd2);
  assign head_valid_o = (cnt_q != 2'd0);
  assign head_o       = q_mem_q[rd_ptr_q];
  assign push         = in_valid_i && !in_stall_o;
  assign pop          = pop_i && head_valid_o;

  always_comb begin
    cnt_d = cnt_q;
    if (push && !pop) cnt_d = cnt_q + 2'd1;
    else if (pop && !push) cnt_d = cnt_q - 2'd1;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      cnt_q    <= 2'd0;
    end else begin
      cnt_q <= cnt_d;
      if (push) wr_ptr_q <= ~wr_ptr_q;
      if (pop) rd_ptr_q <= ~rd_ptr_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) q_mem_q[wr_ptr_q] <= cls;
  end

endmodule
`default_nettype wire

FILE: rtl/snfce_back.sv
// Back end: command sequencer, serial phase engine, page buffer and result register.
// Depends on snfce_pkg.
`timescale 1ns / 1ps
`default_nettype none
module snfce_back #(
  parameter int unsigned PAGE_BYTES = snfce_pkg::PAGE_BYTES_DEF
) (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              cfg_we_i,
  input  wire logic [1:0]        cfg_idx_i,
  input  wire logic [15:0]       cfg_wdata_i,
  input  wire logic              head_valid_i,
  input  wire snfce_pkg::qitem_t head_i,
  output logic                   pop_o,
  output logic                   out_valid_o,
  input  wire logic              out_stall_i,
  output snfce_pkg::out_t        out_data_o
);

  localparam int unsigned AW  = (PAGE_BYTES > 1) ? $clog2(PAGE_BYTES) : 1;
  localparam int unsigned LPW = $clog2(PAGE_BYTES + 1);
  localparam int unsigned BIW = $clog2(PAGE_BYTES + 6);

  logic [15:0] wake_q;
  logic [7:0]  maker_q, part_q;

  snfce_pkg::seq_e st_q, st_d;
  logic [2:0]     op_q, op_d;
  logic [7:0]     tx_q, tx_d, rx_q, rx_d, rx_new;
  logic [2:0]     bit_q, bit_d;
  logic [BIW-1:0] bidx_q, bidx_d, bidx_inc, pdiff, total;
  logic [23:0]    addr_q, addr_d;
  logic [LPW-1:0] len_q, len_d, lp_q, lp_d;
  logic [15:0]    dly_q, dly_d;
  logic           mism_q, mism_d, busy_q, busy_d;
  logic           sclk_q, sclk_d, mosi_q, mosi_d, cs_q, cs_d;
  logic           rd_pend_q, rd_pend_d;
  logic           out_valid_q;
  snfce_pkg::out_t out_q, res;

  logic [7:0] page_q [PAGE_BYTES];
  logic [7:0] rdata_q;
  logic       can_go, in_page, need_rd, rd_en, wr_en;
  snfce_pkg::in_t it;

  assign it      = head_i.item;
  assign can_go  = head_valid_i && (!out_valid_q || !out_stall_i);
  assign pdiff   = bidx_q - BIW'(4);
  assign in_page = (bidx_q >= BIW'(4)) && (pdiff < BIW'(PAGE_BYTES));
  assign need_rd = head_valid_i && head_i.is_tick && (st_q == snfce_pkg::ST_MAIN) && sclk_q &&
                   (bit_q == 3'd0) && (op_q == snfce_pkg::OP_PROG) && in_page;
  // A tick that starts a page byte is held back while the registered buffer read is made.
  assign rd_en   = need_rd && !rd_pend_q;
  assign pop_o   = can_go && !rd_en;
  assign wr_en   = pop_o && head_i.is_load && (lp_q < LPW'(PAGE_BYTES));
  assign rx_new  = {rx_q[6:0], it.miso_bit};
  assign bidx_inc = bidx_q + BIW'(1);

  always_comb begin
    case (op_q)
      snfce_pkg::OP_READ:  total = BIW'(5) + BIW'(len_q);
      snfce_pkg::OP_PROG:  total = BIW'(4) + BIW'(len_q);
      snfce_pkg::OP_ERASE: total = BIW'(4);
      snfce_pkg::OP_WAKE:  total = BIW'(5);
      snfce_pkg::OP_ID:    total = BIW'(6);
      default:             total = BIW'(1);
    endcase
  end

  always_comb begin
    st_d = st_q; op_d = op_q; tx_d = tx_q; rx_d = rx_q; bit_d = bit_q;
    bidx_d = bidx_q; addr_d = addr_q; len_d = len_q; lp_d = lp_q; dly_d = dly_q;
    mism_d = mism_q; busy_d = busy_q; sclk_d = sclk_q; mosi_d = mosi_q; cs_d = cs_q;
    res = '0;
    if (head_i.is_cmd) begin
      if ((st_q != snfce_pkg::ST_IDLE) || !head_i.op_ok) begin
        res.cmd_rejected = 1'b1;
      end else begin
        op_d   = it.op_code;
        addr_d = it.flash_address;
        len_d  = (it.byte_count > 9'(PAGE_BYTES)) ? LPW'(PAGE_BYTES) : LPW'(it.byte_count);
        bidx_d = '0;
        bit_d  = '0;
        busy_d = 1'b0;
        if (it.op_code == snfce_pkg::OP_PROG) lp_d = '0;
        case (it.op_code) inside
          snfce_pkg::OP_READ, snfce_pkg::OP_PROG, snfce_pkg::OP_WREN,
          snfce_pkg::OP_PDOWN: st_d = snfce_pkg::ST_POLL;
          default:             st_d = snfce_pkg::ST_MAIN;
        endcase
      end
    end else if (head_i.is_load) begin
      if (wr_en) lp_d = lp_q + LPW'(1);
    end else if (head_i.is_tick) begin
      unique case (st_q)
        snfce_pkg::ST_POLL, snfce_pkg::ST_MAIN: begin
          if (sclk_q) begin
            if (bit_q == 3'd0) begin
              if (st_q == snfce_pkg::ST_POLL) begin
                tx_d = (bidx_q == '0) ? snfce_pkg::CMD_STATUS : 8'h00;
              end else if (bidx_q == '0) begin
                tx_d = snfce_pkg::op_byte(op_q);
              end else if (bidx_q <= BIW'(3)) begin
                if (op_q <= snfce_pkg::OP_ERASE) begin
                  case (bidx_q[1:0])
                    2'd1:    tx_d = addr_q[23:16];
                    2'd2:    tx_d = addr_q[15:8];
                    default: tx_d = addr_q[7:0];
                  endcase
                end else begin
                  tx_d = 8'h00;
                end
              end else begin
                tx_d = (op_q == snfce_pkg::OP_PROG && in_page) ? rdata_q : 8'h00;
              end
            end
            cs_d   = 1'b0;
            sclk_d = 1'b0;
            mosi_d = tx_d[7];
          end else begin
            sclk_d = 1'b1;
            rx_d   = rx_new;
            tx_d   = {tx_q[6:0], 1'b0};
            bit_d  = bit_q + 3'd1;
            if (bit_q == 3'd7) begin
              if (st_q == snfce_pkg::ST_POLL) begin
                if (bidx_q == BIW'(1)) busy_d = |(rx_new & snfce_pkg::BUSY_MASK);
                if (bidx_inc >= BIW'(2)) st_d = snfce_pkg::ST_GPOLL;
              end else begin
                if (op_q == snfce_pkg::OP_READ && bidx_q >= BIW'(5)) begin
                  res.read_valid = 1'b1;
                  res.read_byte  = rx_new;
                  res.read_last  = (bidx_inc == total);
                end else if (op_q == snfce_pkg::OP_ID) begin
                  if (bidx_q == BIW'(4)) mism_d = (rx_new != maker_q);
                  else if (bidx_q == BIW'(5) && rx_new != part_q) mism_d = 1'b1;
                end
                if (bidx_inc >= total) st_d = snfce_pkg::ST_GMAIN;
              end
              bidx_d = bidx_inc;
            end
          end
        end
        snfce_pkg::ST_GPOLL, snfce_pkg::ST_GMAIN: begin
          cs_d = 1'b1; sclk_d = 1'b1; mosi_d = 1'b1;
          bidx_d = '0; bit_d = '0;
          if (st_q == snfce_pkg::ST_GPOLL) begin
            st_d = busy_q ? snfce_pkg::ST_POLL : snfce_pkg::ST_MAIN;
          end else if (op_q == snfce_pkg::OP_WAKE && wake_q != 16'd0) begin
            dly_d = wake_q;
            st_d  = snfce_pkg::ST_WAIT;
          end else begin
            st_d = snfce_pkg::ST_IDLE;
          end
        end
        snfce_pkg::ST_WAIT: begin
          if (dly_q != 16'd0) dly_d = dly_q - 16'd1;
          if (dly_d == 16'd0) st_d = snfce_pkg::ST_IDLE;
        end
        default: ;
      endcase
    end
    res.chip_select_n = cs_d;
    res.serial_clock  = sclk_d;
    res.serial_out    = mosi_d;
    res.ready_res     = (st_d == snfce_pkg::ST_IDLE);
    res.id_mismatch   = mism_d;
  end

  always_comb begin
    rd_pend_d = rd_pend_q;
    if (pop_o) rd_pend_d = 1'b0;
    else if (rd_en) rd_pend_d = 1'b1;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wake_q <= snfce_pkg::WAKE_RST; maker_q <= snfce_pkg::MAKER_RST;
      part_q <= snfce_pkg::PART_RST;
      st_q <= snfce_pkg::ST_IDLE; op_q <= '0; tx_q <= '0; rx_q <= '0; bit_q <= '0;
      bidx_q <= '0; addr_q <= '0; len_q <= '0; lp_q <= '0; dly_q <= '0;
      mism_q <= 1'b0; busy_q <= 1'b0; sclk_q <= 1'b1; mosi_q <= 1'b1; cs_q <= 1'b1;
      rd_pend_q <= 1'b0; out_valid_q <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        case (cfg_idx_i)
          snfce_pkg::CFG_WAKE:  wake_q  <= cfg_wdata_i;
          snfce_pkg::CFG_MAKER: maker_q <= cfg_wdata_i[7:0];
          snfce_pkg::CFG_PART:  part_q  <= cfg_wdata_i[7:0];
          default: ;
        endcase
      end
      rd_pend_q <= rd_pend_d;
      if (pop_o) begin
        st_q <= st_d; op_q <= op_d; tx_q <= tx_d; rx_q <= rx_d; bit_q <= bit_d;
        bidx_q <= bidx_d; addr_q <= addr_d; len_q <= len_d; lp_q <= lp_d; dly_q <= dly_d;
        mism_q <= mism_d; busy_q <= busy_d; sclk_q <= sclk_d; mosi_q <= mosi_d;
        cs_q <= cs_d;
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (pop_o) out_q <= res;
    if (wr_en) page_q[lp_q[AW-1:0]] <= it.load_byte;
    if (rd_en) rdata_q <= page_q[pdiff[AW-1:0]];
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

endmodule
`default_nettype wire

FILE: rtl/spi_nor_flash_command_engine_unit.sv
// SPI NOR flash command engine: one result per item, one item per cycle sustained while the output is not stalled.
// Each item is registered in the queue, then its result in the result register.
// A tick that starts a program data byte is held back while the page buffer is read.
// Reset (async, active low) idles the link high and restores register defaults;
// the page buffer is not cleared.
// Depends on snfce_pkg, snfce_front, snfce_back.
`timescale 1ns / 1ps
`default_nettype none
module spi_nor_flash_command_engine_unit #(
  parameter int unsigned PAGE_BYTES = snfce_pkg::PAGE_BYTES_DEF
) (
  input  wire logic            clk_i,
  input  wire logic            rst_ni,
  input  wire logic            cfg_we_i,
  input  wire logic [1:0]      cfg_idx_i,
  input  wire logic [15:0]     cfg_wdata_i,
  input  wire logic            in_valid_i,
  output logic                 in_stall_o,
  input  wire snfce_pkg::in_t  in_data_i,
  output logic                 out_valid_o,
  input  wire logic            out_stall_i,
  output snfce_pkg::out_t      out_data_o
);

  logic              head_valid, pop;
  snfce_pkg::qitem_t head;

  snfce_front u_front (
    .clk_i, .rst_ni, .in_valid_i, .in_stall_o, .in_data_i,
    .pop_i(pop), .head_valid_o(head_valid), .head_o(head)
  );

  snfce_back #(.PAGE_BYTES(PAGE_BYTES)) u_back (
    .clk_i, .rst_ni, .cfg_we_i, .cfg_idx_i, .cfg_wdata_i,
    .head_valid_i(head_valid), .head_i(head), .pop_o(pop),
    .out_valid_o, .out_stall_i, .out_data_o
  );

endmodule
`default_nettype wire

FILE: rtl/snfce_checker.sv
// Port-level checker for the command engine, bound to the top level.
// Depends on snfce_pkg and assert_macros.svh.
`timescale 1ns / 1ps
`default_nettype none
`include "assert_macros.svh"
module snfce_checker (
  input wire logic            clk_i,
  input wire logic            rst_ni,
  input wire logic            out_valid_o,
  input wire logic            out_stall_i,
  input wire snfce_pkg::out_t out_data_o
);

  `AST_NEXT(a_out_hold, out_valid_o && out_stall_i, out_valid_o && $stable(out_data_o), "result changed while stalled")
  `AST_SAME(a_rd_cs, out_valid_o && out_data_o.read_valid, !out_data_o.chip_select_n, "read byte outside transaction")
  `AST_SAME(a_rd_last, out_valid_o && out_data_o.read_last, out_data_o.read_valid, "last flag without read byte")
  `AST_SAME(a_rd_busy, out_valid_o && out_data_o.read_valid, !out_data_o.ready_res, "read byte while idle")

endmodule

bind spi_nor_flash_command_engine_unit snfce_checker u_chk (.*);
`default_nettype wire

FILE: test/tb.sv
// Self-checking bench for the SPI NOR flash command engine: a clocked driver feeds
// queued items, a clocked monitor predicts every result and checks it.
// Depends on snfce_pkg and spi_nor_flash_command_engine_unit.
`timescale 1ns / 1ps
module tb;
  import snfce_pkg::*;

  localparam int unsigned PAGE = 256;
  localparam logic [7:0] FL_READ  = 8'h0B;
  localparam logic [7:0] FL_PROG  = 8'h02;
  localparam logic [7:0] FL_ERASE = 8'h20;
  localparam logic [7:0] FL_WREN  = 8'h06;
  localparam logic [7:0] FL_PDOWN = 8'hB9;
  localparam logic [7:0] FL_WAKE  = 8'hAB;
  localparam logic [7:0] FL_ID    = 8'h90;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic cfg_we_i = 1'b0;
  logic [1:0] cfg_idx_i = CFG_WAKE;
  logic [15:0] cfg_wdata_i = '0;
  logic in_valid_i = 1'b0;
  logic in_stall_o;
  in_t in_data_i = '0;
  logic out_valid_o;
  logic out_stall_i = 1'b0;
  out_t out_data_o;

  spi_nor_flash_command_engine_unit DUT (
    .clk_i, .rst_ni, .cfg_we_i, .cfg_idx_i, .cfg_wdata_i,
    .in_valid_i, .in_stall_o, .in_data_i,
    .out_valid_o, .out_stall_i, .out_data_o
  );

  always begin
    #1 clk_i = 1'b1;
    #1 clk_i = 1'b0;
  end

  // predictor copy of the engine
  logic [15:0] m_wake;
  logic [7:0]  m_maker, m_part;
  seq_e        m_st;
  logic [2:0]  m_op;
  logic [7:0]  m_tx, m_rx;
  logic [2:0]  m_bit;
  logic [8:0]  m_idx, m_len, m_lptr;
  logic [23:0] m_addr;
  logic [7:0]  m_page [PAGE];
  logic [15:0] m_delay;
  logic        m_mis, m_clk, m_mosi, m_cs, m_busy;

  in_t  pending [$];
  out_t want_q [$];
  int   errors = 0, n_items = 0, n_reads = 0, n_rej = 0, n_results = 0;

  function automatic logic [8:0] frame_bytes();
    case (m_op)
      OP_READ:  return 9'd5 + m_len;
      OP_PROG:  return 9'd4 + m_len;
      OP_ERASE: return 9'd4;
      OP_WAKE:  return 9'd5;
      OP_ID:    return 9'd6;
      default:  return 9'd1;
    endcase
  endfunction

  function automatic logic [7:0] frame_byte();
    if (m_st == ST_POLL) return (m_idx == 0) ? CMD_STATUS : 8'h00;
    if (m_idx == 0) begin
      case (m_op)
        OP_READ:  return FL_READ;
        OP_PROG:  return FL_PROG;
        OP_ERASE: return FL_ERASE;
        OP_WREN:  return FL_WREN;
        OP_PDOWN: return FL_PDOWN;
        OP_WAKE:  return FL_WAKE;
        OP_ID:    return FL_ID;
        default:  return 8'h00;
      endcase
    end
    if (m_idx <= 3) return (m_op <= OP_ERASE) ? 8'(m_addr >> (8 * (3 - m_idx))) : 8'h00;
    if (m_op == OP_PROG && m_idx - 4 < PAGE) return m_page[m_idx - 4];
    return 8'h00;
  endfunction

  function automatic out_t engine_step(in_t it);
    out_t r;
    logic [8:0] tot;
    r = '0;
    case (it.req_type)
      REQ_CMD: begin
        if (m_st != ST_IDLE || it.op_code == OP_BAD) begin
          r.cmd_rejected = 1'b1;
        end else begin
          m_op = it.op_code;
          m_addr = it.flash_address;
          m_len = (it.byte_count > PAGE) ? 9'(PAGE) : it.byte_count;
          m_idx = '0;
          m_bit = '0;
          m_busy = 1'b0;
          if (it.op_code == OP_PROG) m_lptr = '0;
          m_st = (it.op_code inside {OP_READ, OP_PROG, OP_WREN, OP_PDOWN}) ? ST_POLL : ST_MAIN;
        end
      end
      REQ_LOAD: begin
        if (m_lptr < PAGE) begin
          m_page[m_lptr] = it.load_byte;
          m_lptr++;
        end
      end
      REQ_TICK: begin
        if (m_st == ST_POLL || m_st == ST_MAIN) begin
          if (m_clk) begin
            if (m_bit == 0) m_tx = frame_byte();
            m_cs = 1'b0;
            m_clk = 1'b0;
            m_mosi = m_tx[7];
          end else begin
            m_clk = 1'b1;
            m_rx = {m_rx[6:0], it.miso_bit};
            m_tx = m_tx << 1;
            m_bit++;
            if (m_bit == 0) begin
              tot = (m_st == ST_POLL) ? 9'd2 : frame_bytes();
              if (m_st == ST_POLL) begin
                if (m_idx == 1) m_busy = |(m_rx & BUSY_MASK);
              end else if (m_op == OP_READ && m_idx >= 5) begin
                r.read_valid = 1'b1;
                r.read_byte = m_rx;
                r.read_last = (m_idx + 9'd1 == tot);
              end else if (m_op == OP_ID) begin
                if (m_idx == 4) m_mis = (m_rx != m_maker);
                else if (m_idx == 5 && m_rx != m_part) m_mis = 1'b1;
              end
              m_idx++;
              if (m_idx >= tot) m_st = (m_st == ST_POLL) ? ST_GPOLL : ST_GMAIN;
            end
          end
        end else if (m_st == ST_GPOLL || m_st == ST_GMAIN) begin
          m_cs = 1'b1;
          m_clk = 1'b1;
          m_mosi = 1'b1;
          m_idx = '0;
          m_bit = '0;
          if (m_st == ST_GPOLL) m_st = m_busy ? ST_POLL : ST_MAIN;
          else if (m_op == OP_WAKE && m_wake != 0) begin
            m_delay = m_wake;
            m_st = ST_WAIT;
          end else m_st = ST_IDLE;
        end else if (m_st == ST_WAIT) begin
          if (m_delay != 0) m_delay--;
          if (m_delay == 0) m_st = ST_IDLE;
        end
      end
      default: ;
    endcase
    r.chip_select_n = m_cs;
    r.serial_clock = m_clk;
    r.serial_out = m_mosi;
    r.ready_res = (m_st == ST_IDLE);
    r.id_mismatch = m_mis;
    return r;
  endfunction

  // driver: new transfer offered at a falling edge once the previous one was taken and any random gap has run out
  logic took = 1'b0;
  int gap_left = 0, stall_left = 0;
  bit calm = 1'b0;

  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (calm || r < 60) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(4, 25);
  endfunction

  always @(negedge clk_i) begin
    if ($urandom_range(0, 399) == 0) calm <= ~calm;
    if (rst_ni && (!in_valid_i || took)) begin
      if (gap_left > 0 || pending.size() == 0) begin
        in_valid_i <= 1'b0;
        if (gap_left > 0) gap_left <= gap_left - 1;
      end else begin
        in_valid_i <= 1'b1;
        in_data_i <= pending.pop_front();
        gap_left <= pick_gap();
      end
    end
    if (stall_left > 0) begin
      out_stall_i <= 1'b1;
      stall_left <= stall_left - 1;
    end else begin
      out_stall_i <= 1'b0;
      stall_left <= pick_gap();
    end
  end

  task automatic check_field(string name, int want, int got);
    if (want != got) begin
      errors++;
      $display("%0t: %s expected %0h actual %0h", $realtime, name, want, got);
    end
  endtask

  always @(posedge clk_i) begin
    out_t w;
    took <= in_valid_i && !in_stall_o;
    if (out_valid_o && !out_stall_i) begin
      if (want_q.size() == 0) begin
        errors++;
        $display("%0t: unexpected result %0h", $realtime, out_data_o);
      end else begin
        w = want_q.pop_front();
        n_results++;
        check_field("chip_select_n", w.chip_select_n, out_data_o.chip_select_n);
        check_field("serial_clock", w.serial_clock, out_data_o.serial_clock);
        check_field("serial_out", w.serial_out, out_data_o.serial_out);
        check_field("read_byte", w.read_byte, out_data_o.read_byte);
        check_field("read_valid", w.read_valid, out_data_o.read_valid);
        check_field("read_last", w.read_last, out_data_o.read_last);
        check_field("ready_res", w.ready_res, out_data_o.ready_res);
        check_field("id_mismatch", w.id_mismatch, out_data_o.id_mismatch);
        check_field("cmd_rejected", w.cmd_rejected, out_data_o.cmd_rejected);
      end
    end
    if (in_valid_i && !in_stall_o) begin
      w = engine_step(in_data_i);
      n_reads += w.read_valid;
      n_rej += w.cmd_rejected;
      want_q.push_back(w);
    end
  end

  // stimulus helpers
  task automatic put(req_e req, op_e op, logic [23:0] addr, logic [8:0] cnt,
                     logic [7:0] lb, logic miso);
    in_t it;
    it.req_type = req;
    it.op_code = op;
    it.flash_address = addr;
    it.byte_count = cnt;
    it.load_byte = lb;
    it.miso_bit = miso;
    pending.push_back(it);
    n_items++;
  endtask

  // miso modes: 0 quiet, 1 random, 2 ID bytes at their slots
  task automatic ticks(int n, int mode, logic [7:0] mk, logic [7:0] pt);
    logic b;
    for (int k = 0; k < n; k++) begin
      b = $urandom_range(0, 1);
      if (mode == 0) b = 1'b0;
      else if (mode == 2 && k / 16 == 4) b = mk[7 - (k % 16) / 2];
      else if (mode == 2 && k / 16 == 5) b = pt[7 - (k % 16) / 2];
      put(REQ_TICK, op_e'($urandom_range(0, 7)), $urandom, $urandom, $urandom, b);
    end
  endtask

  task automatic run_cmd(op_e op, logic [23:0] addr, logic [8:0] cnt, int mode,
                         int extra, logic [7:0] mk, logic [7:0] pt);
    int len, tot, n;
    len = (cnt > PAGE) ? PAGE : cnt;
    case (op)
      OP_READ:  tot = 5 + len;
      OP_PROG:  tot = 4 + len;
      OP_ERASE: tot = 4;
      OP_WAKE:  tot = 5;
      OP_ID:    tot = 6;
      default:  tot = 1;
    endcase
    n = 16 * tot + 1 + extra;
    if (op inside {OP_READ, OP_PROG, OP_WREN, OP_PDOWN}) n += 33;
    if (op == OP_WAKE) n += m_wake;
    put(REQ_CMD, op, addr, cnt, $urandom, $urandom);
    ticks((n < 0) ? 0 : n, mode, mk, pt);
  endtask

  task automatic write_reg(logic [1:0] idx, logic [15:0] val);
    @(negedge clk_i);
    cfg_we_i <= 1'b1;
    cfg_idx_i <= idx;
    cfg_wdata_i <= val;
    case (idx)
      CFG_WAKE:  m_wake = val;
      CFG_MAKER: m_maker = val[7:0];
      default:   m_part = val[7:0];
    endcase
    @(negedge clk_i);
    cfg_we_i <= 1'b0;
  endtask

  task automatic drain();
    wait (pending.size() == 0 && !in_valid_i && want_q.size() == 0);
    repeat (12) @(negedge clk_i);
  endtask

  task automatic random_mix(int count);
    int stop, r, len, mode;
    op_e op;
    logic [7:0] mk, pt;
    stop = n_items + count;
    while (n_items < stop) begin
      r = $urandom_range(0, 99);
      if (r < 70) begin
        op = op_e'($urandom_range(0, 6));
        len = ($urandom_range(0, 49) == 0) ? $urandom_range(7, 12) : $urandom_range(0, 6);
        mode = ($urandom_range(0, 2) == 0) ? 1 : 0;
        mk = m_maker;
        pt = m_part;
        if (op == OP_ID) begin
          mode = 2;
          if ($urandom_range(0, 2) == 0) mk = $urandom;
          if ($urandom_range(0, 2) == 0) pt = $urandom;
        end
        run_cmd(op, $urandom, len, mode, $urandom_range(0, 3), mk, pt);
      end else if (r < 80) begin
        repeat ($urandom_range(1, 10)) put(REQ_LOAD, OP_READ, $urandom, $urandom, $urandom, 1'b0);
      end else if (r < 90) begin
        put(req_e'($urandom_range(0, 3)), op_e'($urandom_range(0, 7)), $urandom,
            $urandom, $urandom, $urandom);
      end else begin
        // command cut short so the next one hits a busy engine
        run_cmd(op_e'($urandom_range(0, 6)), $urandom, $urandom_range(0, 4), 1,
                -$urandom_range(1, 40), m_maker, m_part);
      end
    end
  endtask

  initial begin
    m_wake = WAKE_RST; m_maker = MAKER_RST; m_part = PART_RST;
    m_st = ST_IDLE; m_op = OP_READ; m_tx = '0; m_rx = '0; m_bit = '0;
    m_idx = '0; m_len = '0; m_lptr = '0; m_addr = '0; m_delay = '0;
    m_mis = 1'b0; m_clk = 1'b1; m_mosi = 1'b1; m_cs = 1'b1; m_busy = 1'b0;
    repeat (6) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    // whole page written first, plus one load into the full buffer
    for (int i = 0; i <= PAGE; i++) put(REQ_LOAD, OP_READ, '0, '0, i * 37 + 5, 1'b0);
    run_cmd(OP_READ, 24'hFFFFFF, 9'd2, 1, 0, 0, 0);
    run_cmd(OP_PROG, 24'h5AA5C3, 9'd2, 0, 0, 0, 0);
    run_cmd(OP_ERASE, 24'hA55A3C, 9'd0, 1, 0, 0, 0);
    run_cmd(OP_WREN, 24'h0, 9'd0, 1, 0, 0, 0);
    run_cmd(OP_PDOWN, 24'h0, 9'd0, 0, 0, 0, 0);
    run_cmd(OP_WAKE, 24'h0, 9'd0, 1, 0, 0, 0);
    run_cmd(OP_ID, 24'h0, 9'd0, 2, 0, 8'h00, PART_RST);
    put(REQ_CMD, OP_BAD, '1, '1, '1, 1'b1);
    put(REQ_CMD, OP_ERASE, 24'h123456, '0, '0, 1'b0);
    put(REQ_CMD, OP_READ, '0, '0, '0, 1'b0);
    put(REQ_NONE, OP_ID, '1, '1, '1, 1'b1);
    ticks(40, 1, 0, 0);
    drain();

    write_reg(CFG_WAKE, 16'd50);
    write_reg(CFG_MAKER, 16'h0000);
    write_reg(CFG_PART, 16'h0000);
    run_cmd(OP_WAKE, '0, '0, 0, 2, 0, 0);
    run_cmd(OP_ID, '0, '0, 2, 0, 8'h00, 8'h00);
    run_cmd(OP_ID, '0, '0, 2, 0, 8'h00, 8'h01);
    drain();

    write_reg(CFG_WAKE, 16'h0000);
    write_reg(CFG_MAKER, 16'h00FF);
    write_reg(CFG_PART, 16'h00FF);
    random_mix(120);
    drain();

    for (int p = 0; p < 2; p++) begin
      write_reg(CFG_WAKE, $urandom_range(1, 40));
      write_reg(CFG_MAKER, $urandom_range(0, 255));
      write_reg(CFG_PART, $urandom_range(0, 255));
      random_mix(120);
      drain();
    end

    $display("covered %0d items, %0d results, %0d read bytes, %0d dropped commands",
             n_items, n_results, n_reads, n_rej);
    $display("config swept: wake delay 0, 30, 50 and random; ID bytes 0x00, 0xff, random");
    if (errors == 0) $display("end of test: clean");
    else $display("end of test: mismatches");
    $finish;
  end

  initial begin
    #20_000_000;
    $display("timeout");
    $display("end of test: mismatches");
    $finish;
  end

endmodule

FILE: filelist.f
+incdir+rtl
rtl/snfce_pkg.sv
rtl/snfce_front.sv
rtl/snfce_back.sv
rtl/spi_nor_flash_command_engine_unit.sv
rtl/snfce_checker.sv
test/tb.sv
